[hdl/dsu_pkg.sv]
`default_nettype none

package dsu_pkg;

  localparam int NODE_W = 10;
  localparam int CMD_W  = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_FIND  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SAME  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNION = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } req_t;

  typedef struct packed {
    logic [NODE_W-1:0] root_a;
    logic [NODE_W-1:0] root_b;
    logic              in_same_set;
    logic              merged;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LAUNCH,
    ST_WALK,
    ST_COMP,
    ST_NEXT,
    ST_SIZE_A,
    ST_SIZE_B
  } state_t;

endpackage

`default_nettype wire

[hdl/dsu_ram.sv]
`default_nettype none

module dsu_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 10,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[hdl/disjoint_set_union_engine_unit.sv]
`default_nettype none

// union-find engine with path compression and union by size
//
// request channel: a request (command, node_a, node_b) is taken at a rising
// edge with start high and busy low. commands: find root of node_a, same-set
// query, union of the two sets. any other code returns all-zero fields.
// result channel: done pulses for one cycle with the result on 'result';
// the receiver cannot stall, so the result is simply dropped if not taken.
// the next request may be issued in the same cycle that done is high.
//
// one table read per cycle through the parent table's single read port. a
// walk of node n follows the links up to the root, then restarts at n and
// points every node on the path straight at the root (skipped when n is the
// root itself). a find walks node_a, a same-set query walks node_a and then
// node_b, and a union then reads both set sizes and, if the roots differ and
// both are in range, hangs the smaller root under the larger one. depth stays
// at or below log2(NUM_NODES) under union by size.
//
// reset: after rst the block runs a clearing pass over every entry of
// both tables (every node its own root, every set size one); busy is high
// until it finishes.

module disjoint_set_union_engine_unit #(
  parameter int NUM_NODES = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire dsu_pkg::req_t request,
  output logic               done,
  output dsu_pkg::rsp_t      result
);

  import dsu_pkg::*;

  localparam int IDX_W  = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
  localparam int SIZE_W = $clog2(NUM_NODES + 1);

  // node indices at or beyond NUM_NODES are isolated singletons
  function automatic logic out_of_range(input logic [NODE_W-1:0] n);
    return int'(n) >= NUM_NODES;
  endfunction

  state_t state, state_next;

  // latched request
  logic [CMD_W-1:0]  cmd;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;

  // walk registers
  logic              phase;     // 0 walking node_a, 1 walking node_b
  logic [IDX_W-1:0]  cur;
  logic [IDX_W-1:0]  origin;
  logic [NODE_W-1:0] root;
  logic [NODE_W-1:0] ra;
  logic [NODE_W-1:0] rb;
  logic [SIZE_W-1:0] size_a;
  logic [IDX_W-1:0]  clr_idx;

  // table ports
  logic              par_we;
  logic [IDX_W-1:0]  par_waddr;
  logic [IDX_W-1:0]  par_wdata;
  logic [IDX_W-1:0]  par_raddr;
  logic [IDX_W-1:0]  par_rdata;
  logic              siz_we;
  logic [IDX_W-1:0]  siz_waddr;
  logic [SIZE_W-1:0] siz_wdata;
  logic [IDX_W-1:0]  siz_raddr;
  logic [SIZE_W-1:0] siz_rdata;

  // derived values
  logic [NODE_W-1:0] walk_node;
  logic              clr_last;
  logic              same_now;
  logic              do_union;
  logic              b_bigger;
  logic [NODE_W-1:0] big;
  logic [NODE_W-1:0] little;

  assign walk_node = phase ? node_b : node_a;
  assign clr_last  = (clr_idx == IDX_W'(NUM_NODES - 1));
  assign same_now  = (ra == root);
  assign do_union  = (cmd == CMD_UNION) && !same_now &&
                     !out_of_range(ra) && !out_of_range(root);
  assign b_bigger  = (size_a < siz_rdata);
  assign big       = b_bigger ? rb : ra;
  assign little    = b_bigger ? ra : rb;
  assign busy      = (state != ST_IDLE);

  dsu_ram #(
    .DEPTH (NUM_NODES),
    .WIDTH (IDX_W)
  ) u_parent (
    .clk     (clk),
    .wr_en   (par_we),
    .wr_addr (par_waddr),
    .wr_data (par_wdata),
    .rd_addr (par_raddr),
    .rd_data (par_rdata)
  );

  dsu_ram #(
    .DEPTH (NUM_NODES),
    .WIDTH (SIZE_W)
  ) u_size (
    .clk     (clk),
    .wr_en   (siz_we),
    .wr_addr (siz_waddr),
    .wr_data (siz_wdata),
    .rd_addr (siz_raddr),
    .rd_data (siz_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          unique case (request.command) inside
            CMD_FIND, CMD_SAME, CMD_UNION: state_next = ST_LAUNCH;
            default:                       state_next = ST_IDLE;
          endcase
        end
      end
      ST_LAUNCH: begin
        if (out_of_range(walk_node)) state_next = ST_NEXT;
        else                         state_next = ST_WALK;
      end
      ST_WALK: begin
        // root found: compress unless the start node is the root itself
        if (par_rdata == cur) begin
          state_next = (origin == cur) ? ST_NEXT : ST_COMP;
        end
      end
      ST_COMP: begin
        if (par_rdata == IDX_W'(root)) state_next = ST_NEXT;
      end
      ST_NEXT: begin
        if (!phase) begin
          state_next = (cmd == CMD_FIND) ? ST_IDLE : ST_LAUNCH;
        end else begin
          state_next = do_union ? ST_SIZE_A : ST_IDLE;
        end
      end
      ST_SIZE_A: state_next = ST_SIZE_B;
      ST_SIZE_B: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // table controls
  always_comb begin
    par_we    = 1'b0;
    par_waddr = clr_idx;
    par_wdata = clr_idx;
    par_raddr = cur;
    siz_we    = 1'b0;
    siz_waddr = clr_idx;
    siz_wdata = SIZE_W'(1);
    siz_raddr = IDX_W'(ra);
    unique case (state)
      ST_CLEAR: begin
        par_we = 1'b1;
        siz_we = 1'b1;
      end
      ST_LAUNCH: begin
        par_raddr = IDX_W'(walk_node);
      end
      ST_WALK: begin
        // follow the link, or restart at the origin for compression
        par_raddr = (par_rdata == cur) ? origin : par_rdata;
      end
      ST_COMP: begin
        par_we    = 1'b1;
        par_waddr = cur;
        par_wdata = IDX_W'(root);
        par_raddr = par_rdata;
      end
      ST_NEXT: begin
        siz_raddr = IDX_W'(ra);
      end
      ST_SIZE_A: begin
        siz_raddr = IDX_W'(rb);
      end
      ST_SIZE_B: begin
        // hang the smaller root under the larger one
        par_we    = 1'b1;
        par_waddr = IDX_W'(little);
        par_wdata = IDX_W'(big);
        siz_we    = 1'b1;
        siz_waddr = IDX_W'(big);
        siz_wdata = size_a + siz_rdata;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == ST_IDLE && start && state_next == ST_IDLE) begin
        done <= 1'b1;
      end
      if (state == ST_NEXT && state_next == ST_IDLE) begin
        done <= 1'b1;
      end
      if (state == ST_SIZE_B) begin
        done <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd    <= request.command;
          node_a <= request.node_a;
          node_b <= request.node_b;
          phase  <= 1'b0;
          result <= '0;
        end
      end
      ST_LAUNCH: begin
        cur    <= IDX_W'(walk_node);
        origin <= IDX_W'(walk_node);
        root   <= walk_node;
      end
      ST_WALK: begin
        if (par_rdata == cur) begin
          root <= NODE_W'(cur);
          cur  <= origin;
        end else begin
          cur <= par_rdata;
        end
      end
      ST_COMP: begin
        cur <= par_rdata;
      end
      ST_NEXT: begin
        if (!phase) begin
          ra     <= root;
          phase  <= 1'b1;
          result <= '{root_a: root, root_b: '0, in_same_set: 1'b0, merged: 1'b0};
        end else begin
          rb     <= root;
          result <= '{root_a: ra, root_b: root, in_same_set: same_now, merged: 1'b0};
        end
      end
      ST_SIZE_A: begin
        size_a <= siz_rdata;
      end
      ST_SIZE_B: begin
        result.root_a <= big;
        result.merged <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[verif/disjoint_set_union_engine_unit_test.sv]
`timescale 1ns / 100ps

module disjoint_set_union_engine_unit_test;
  import dsu_pkg::*;

  localparam int NODES = 1024;
  // the one command code the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  // longest request walks two chains of about log2(NODES) links each
  localparam int SETTLE_CYCLES = 60;

  // everything the block sees is known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t request = '0;
  logic busy;
  logic done;
  rsp_t result;

  // own copy of the forest, tracked request by request
  logic [NODE_W-1:0] parent_of [NODES];
  logic [NODE_W:0]   set_count [NODES];

  // results owed by the block, oldest first
  rsp_t pending_results [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  // chance in percent that the sender pauses after a request
  int   sender_idle_pct = 0;
  // node window used to grow local clusters in the random traffic
  int   cluster_base = 0;

  disjoint_set_union_engine_unit #(.NUM_NODES(NODES)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #6 clk = ~clk;

  // walk up to the root, then point every node on the path straight at it
  function automatic logic [NODE_W-1:0] resolve_root(logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] root;
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] nxt;
    int steps;
    root = node;
    steps = 0;
    while (parent_of[root] != root && steps < NODES) begin
      root = parent_of[root];
      steps++;
    end
    cur = node;
    steps = 0;
    while (cur != root && steps < NODES) begin
      nxt = parent_of[cur];
      parent_of[cur] = root;
      cur = nxt;
      steps++;
    end
    return root;
  endfunction

  // expected result of one request, updating the forest copy as the block would
  function automatic rsp_t apply_request(req_t req);
    rsp_t rsp;
    logic [NODE_W-1:0] big;
    logic [NODE_W-1:0] little;
    rsp = '0;
    case (req.command)
      CMD_FIND: begin
        rsp.root_a = resolve_root(req.node_a);
      end
      CMD_SAME, CMD_UNION: begin
        rsp.root_a = resolve_root(req.node_a);
        rsp.root_b = resolve_root(req.node_b);
        rsp.in_same_set = (rsp.root_a == rsp.root_b);
        if (req.command == CMD_UNION && !rsp.in_same_set) begin
          // larger set wins, ties keep the root of node_a
          big = rsp.root_a;
          little = rsp.root_b;
          if (set_count[rsp.root_a] < set_count[rsp.root_b]) begin
            big = rsp.root_b;
            little = rsp.root_a;
          end
          parent_of[little] = big;
          set_count[big] = set_count[big] + set_count[little];
          rsp.root_a = big;
          rsp.merged = 1'b1;
        end
      end
      default: ;  // unused code: no state change, all fields zero
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
             what, cycle_count, want, got);
    mismatch_count++;
  endtask

  // present one request and hold it until the block takes it
  task automatic send_request(logic [CMD_W-1:0] command, int a, int b);
    req_t req;
    rsp_t owed;
    req.command = command;
    req.node_a = a[NODE_W-1:0];
    req.node_b = b[NODE_W-1:0];
    request <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    owed = apply_request(req);
    pending_results = {pending_results, owed};
    // a pause of random length, so start is sometimes low while the block waits idle
    if ($urandom_range(1, 100) <= sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // result checker: the block pulses done for one cycle, nothing can hold it
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("results outstanding", 0, 1);
      end else begin
        rsp_t want;
        want = pending_results.pop_front();
        if (result.root_a !== want.root_a)
          report_mismatch("root_a", want.root_a, result.root_a);
        if (result.root_b !== want.root_b)
          report_mismatch("root_b", want.root_b, result.root_b);
        if (result.in_same_set !== want.in_same_set)
          report_mismatch("in_same_set", want.in_same_set, result.in_same_set);
        if (result.merged !== want.merged)
          report_mismatch("merged", want.merged, result.merged);
      end
    end
  end

  // watchdog: a hung handshake or a lost result ends up here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("FAIL disjoint_set_union_engine_unit");
      $finish;
    end
  end

  // untouched forest: every node is its own root
  task automatic test_reset_forest();
    send_request(CMD_FIND, 0, 1023);
    send_request(CMD_FIND, 1023, 0);
    send_request(CMD_SAME, 0, 1023);
    send_request(CMD_SAME, 512, 512);
  endtask

  // unused code with every bit of both nodes toggled
  task automatic test_unused_command();
    send_request(CMD_UNUSED, 1023, 1023);
    send_request(CMD_UNUSED, 'h2AA, 'h155);
    send_request(CMD_UNUSED, 'h155, 'h2AA);
  endtask

  // tie keeps node_a's root, larger set wins, union within a set is a no-op
  task automatic test_union_rules();
    send_request(CMD_UNION, 0, 1023);
    send_request(CMD_UNION, 1023, 0);
    send_request(CMD_UNION, 700, 0);
    send_request(CMD_UNION, 1, 2);
    send_request(CMD_UNION, 3, 1);
    send_request(CMD_UNION, 1, 1);
    send_request(CMD_UNION, 3, 0);
    send_request(CMD_SAME, 700, 2);
  endtask

  // build a chain three links deep, then walk it so the path gets flattened
  task automatic test_path_compression();
    send_request(CMD_UNION, 10, 11);
    send_request(CMD_UNION, 12, 13);
    send_request(CMD_UNION, 14, 15);
    send_request(CMD_UNION, 16, 17);
    send_request(CMD_UNION, 14, 16);
    send_request(CMD_UNION, 10, 12);
    send_request(CMD_UNION, 10, 14);
    send_request(CMD_FIND, 17, 0);
    send_request(CMD_SAME, 13, 15);
    send_request(CMD_FIND, 17, 0);
  endtask

  // unions, finds and same-set queries, mostly inside a drifting window so trees get deep, plus
  // far-flung nodes and the odd unused code as noise
  task automatic test_random_traffic(int count, int idle_pct);
    int pick;
    int a;
    int b;
    logic [CMD_W-1:0] command;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0)
        cluster_base = $urandom_range(0, NODES - 1);
      pick = $urandom_range(1, 100);
      if (pick <= 25)
        command = CMD_FIND;
      else if (pick <= 50)
        command = CMD_SAME;
      else if (pick <= 95)
        command = CMD_UNION;
      else
        command = CMD_UNUSED;
      if ($urandom_range(1, 100) <= 65) begin
        a = (cluster_base + $urandom_range(0, 47)) % NODES;
        b = (cluster_base + $urandom_range(0, 47)) % NODES;
      end else begin
        a = $urandom_range(0, NODES - 1);
        b = $urandom_range(0, NODES - 1);
      end
      send_request(command, a, b);
    end
  endtask

  initial begin
    for (int n = 0; n < NODES; n++) begin
      parent_of[n] = n[NODE_W-1:0];
      set_count[n] = 1;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // block clears its tables after reset; the handshake waits it out
    test_reset_forest();
    test_unused_command();
    test_union_rules();
    test_path_compression();
    test_random_traffic(500, 0);
    test_random_traffic(500, 71);
    test_random_traffic(500, 0);
    test_random_traffic(500, 17);

    // let the last results drain, then a little slack for stray strobes
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("PASS disjoint_set_union_engine_unit");
    else
      $display("FAIL disjoint_set_union_engine_unit");
    $finish;
  end

endmodule
